FILE: hw/rtl/cas_pkg.sv
package cas_pkg;

	localparam int PosW   = 24;
	localparam int PowW   = 16;
	localparam int TiltW  = 16;
	localparam int CfgW   = 24;
	localparam int CfgIdxW = 3;

	localparam logic signed [PowW-1:0] FullScale  = 16'sd16384;
	localparam logic signed [PowW-1:0] HomePower  = 16'sd1638;
	localparam logic signed [PowW-1:0] LevelPower = 16'sd3277;
	localparam logic [12:0] ManualScale = 13'd4915;
	localparam logic [7:0]  TickMax     = 8'd255;

	localparam logic [1:0] PISTON_OFF = 2'd0;
	localparam logic [1:0] PISTON_FWD = 2'd1;
	localparam logic [1:0] PISTON_REV = 2'd2;

	localparam logic [CfgIdxW-1:0] REG_RAISE_TARGET = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_LOWER_TARGET = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_CLIMB_TARGET = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_PISTON_LIMIT = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_TILT_BAND    = 3'd4;
	localparam logic [CfgIdxW-1:0] REG_DEADBAND     = 3'd5;
	localparam logic [CfgIdxW-1:0] REG_ZERO_TIMEOUT = 3'd6;
	localparam logic [CfgIdxW-1:0] REG_CLIMB_POWER  = 3'd7;

	typedef struct packed {
		logic signed [PosW-1:0]  left_pos;
		logic signed [PosW-1:0]  right_pos;
		logic [1:0]              limits;
		logic signed [TiltW-1:0] tilt;
		logic signed [PowW-1:0]  left_stick;
		logic signed [PowW-1:0]  right_stick;
		logic [4:0]              buttons;
		logic [2:0]              modes;
	} in_word_t;

	typedef struct packed {
		logic signed [PowW-1:0] left_power;
		logic signed [PowW-1:0] right_power;
		logic [1:0]             arm_piston;
		logic                   reset_encoders;
		logic                   homing_active;
		logic                   moving_arms;
		logic                   arms_raised;
		logic                   climbing_active;
		logic                   request_consumed;
	} out_word_t;

	// clamp a widened command to full scale
	function automatic logic signed [PowW-1:0] sat_cmd(input logic signed [PowW:0] v);
		logic signed [PowW:0] hi;
		logic signed [PowW:0] lo;
		hi = {1'b0, FullScale};
		lo = -hi;
		if (v > hi) begin
			sat_cmd = FullScale;
		end else if (v < lo) begin
			sat_cmd = -FullScale;
		end else begin
			sat_cmd = v[PowW-1:0];
		end
	endfunction

endpackage

FILE: hw/rtl/climber_arm_sequencer.sv
// pipeline: a word is taken into the input register, then goes through the command logic
// into the result register; its result word is offered once that register is free
// throughput: one word per cycle, limited only by result_ready
// reset: arst_n asynchronously clears both handshakes, loads default registers and
// starts the homing sequence with motors stopped and piston off
module climber_arm_sequencer (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            item_valid,
	output logic                            item_ready,
	input  cas_pkg::in_word_t               item,
	output logic                            result_valid,
	input  logic                            result_ready,
	output cas_pkg::out_word_t              result,
	input  logic                            cfg_we,
	input  logic [cas_pkg::CfgIdxW-1:0]     cfg_index,
	input  logic [cas_pkg::CfgW-1:0]        cfg_data
);
	import cas_pkg::*;

	// configuration
	logic signed [PosW-1:0] raise_target_q, lower_target_q, climb_target_q, piston_limit_q;
	logic [14:0]            tilt_band_q, deadband_q;
	logic [7:0]             zero_timeout_q;
	logic signed [PowW-1:0] climb_power_q;

	// sequencer state
	logic                   homing_q, seq_run_q, raised_q, climb_on_q;
	logic [7:0]             homing_ticks_q;
	logic signed [PowW-1:0] left_cmd_q, right_cmd_q;
	logic [1:0]             piston_q;

	logic      valid_s1;
	in_word_t  item_s1;
	logic      out_valid_q;
	out_word_t out_q;
	logic      advance;

	// next-state values
	logic                   homing_n, seq_run_n, raised_n, climb_on_n;
	logic [7:0]             homing_ticks_n;
	logic signed [PowW-1:0] left_n, right_n;
	logic [1:0]             piston_n;
	logic                   pulse_n, consumed_n;

	logic signed [PowW-1:0] left_scaled, right_scaled;

	assign advance      = valid_s1 && (!out_valid_q || result_ready);
	assign item_ready   = !valid_s1 || advance;
	assign result_valid = out_valid_q;
	assign result       = out_q;

	function automatic logic signed [PowW-1:0] scale_stick(input logic signed [PowW-1:0] s);
		logic signed [PowW:0] wide;
		logic [PowW-1:0]      mag;
		logic [28:0]          prod;
		logic [14:0]          q;
		wide = {s[PowW-1], s};
		mag  = s[PowW-1] ? 16'(-wide) : s;
		prod = 29'(mag) * 29'(ManualScale);
		q    = 15'((prod + 29'd8192) >> 14);
		scale_stick = s[PowW-1] ? -$signed({1'b0, q}) : $signed({1'b0, q});
	endfunction

	always_comb begin
		left_scaled  = scale_stick(item_s1.left_stick);
		right_scaled = scale_stick(item_s1.right_stick);
	end

	always_comb begin
		logic                   lim_l, lim_r, climb_en, manual, auton;
		logic signed [PowW:0]   pw, npw;
		logic signed [PowW:0]   ls, rs, db;
		logic signed [TiltW:0]  tl, band;
		logic signed [PosW-1:0] lp, rp;
		lim_l    = item_s1.limits[0];
		lim_r    = item_s1.limits[1];
		climb_en = item_s1.modes[0];
		manual   = item_s1.modes[1];
		auton    = item_s1.modes[2];
		lp       = item_s1.left_pos;
		rp       = item_s1.right_pos;
		pw       = {climb_power_q[PowW-1], climb_power_q};
		npw      = -pw;
		ls       = {item_s1.left_stick[PowW-1], item_s1.left_stick};
		rs       = {item_s1.right_stick[PowW-1], item_s1.right_stick};
		db       = {2'b00, deadband_q};
		tl       = {item_s1.tilt[TiltW-1], item_s1.tilt};
		band     = {2'b00, tilt_band_q};

		homing_n       = homing_q;
		homing_ticks_n = homing_ticks_q;
		seq_run_n      = seq_run_q;
		raised_n       = raised_q;
		climb_on_n     = climb_on_q;
		left_n         = left_cmd_q;
		right_n        = right_cmd_q;
		piston_n       = piston_q;
		pulse_n        = 1'b0;
		consumed_n     = 1'b0;

		if (homing_q) begin
			if (homing_ticks_q != TickMax) begin
				homing_ticks_n = homing_ticks_q + 8'd1;
			end
			if (item_s1.buttons[0]) begin
				pulse_n  = 1'b1;
				left_n   = '0;
				right_n  = '0;
				homing_n = 1'b0;
			end else if (homing_ticks_n > zero_timeout_q && auton) begin
				left_n  = '0;
				right_n = '0;
			end else begin
				left_n  = lim_l ? '0 : HomePower;
				right_n = lim_r ? '0 : HomePower;
				if (lim_l && lim_r) begin
					pulse_n  = 1'b1;
					piston_n = PISTON_FWD;
					homing_n = 1'b0;
				end
			end
		end else if (manual) begin
			if (climb_en) begin
				climb_on_n = 1'b0;
				left_n     = (ls > db || ls < -db) ? left_scaled : '0;
				right_n    = (rs > db || rs < -db) ? right_scaled : '0;
				piston_n   = (lp < piston_limit_q || rp < piston_limit_q) ?
					PISTON_REV : PISTON_FWD;
			end
		end else if (climb_en) begin
			if (item_s1.buttons[3]) begin
				consumed_n = 1'b1;
				if (!climb_on_q && !raised_q && !seq_run_q) begin
					piston_n = item_s1.buttons[4] ? PISTON_FWD : PISTON_REV;
				end
			end
			if (item_s1.buttons[1]) begin
				seq_run_n = 1'b1;
			end

			if (seq_run_n && !raised_q) begin
				if (rp > raise_target_q || lp > raise_target_q) begin
					piston_n = PISTON_REV;
					left_n   = (lp > raise_target_q) ? sat_cmd(npw) : '0;
					right_n  = (rp > raise_target_q) ? sat_cmd(npw) : '0;
				end else begin
					left_n    = '0;
					right_n   = '0;
					raised_n  = 1'b1;
					seq_run_n = 1'b0;
				end
			end else if (seq_run_n && raised_q) begin
				// arms still below the lower target are driven toward it with the climb power
				if (rp < lower_target_q || lp < lower_target_q) begin
					left_n  = (lp < lower_target_q) ? sat_cmd(pw) : '0;
					right_n = (rp < lower_target_q) ? sat_cmd(pw) : '0;
				end else begin
					left_n    = '0;
					right_n   = '0;
					piston_n  = PISTON_FWD;
					raised_n  = 1'b0;
					seq_run_n = 1'b0;
				end
			end

			if (item_s1.buttons[2]) begin
				climb_on_n = 1'b1;
			end

			if (climb_on_n) begin
				if (lp < climb_target_q || rp < climb_target_q) begin
					// tilt on the band edge holds the commands
					if (tl < band && tl > -band) begin
						left_n  = sat_cmd(pw);
						right_n = sat_cmd(pw);
					end else if (tl > band) begin
						left_n  = sat_cmd(pw);
						right_n = '0;
					end else if (tl < -band) begin
						left_n  = '0;
						right_n = sat_cmd(pw);
					end
				end else begin
					if (tl > band) begin
						left_n = LevelPower;
					end else if (tl < -band) begin
						left_n = -LevelPower;
					end else begin
						left_n  = '0;
						right_n = '0;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raise_target_q <= -24'sd20480;
			lower_target_q <= -24'sd1280;
			climb_target_q <= -24'sd7680;
			piston_limit_q <= -24'sd2560;
			tilt_band_q    <= 15'd1024;
			deadband_q     <= 15'd1638;
			zero_timeout_q <= 8'd75;
			climb_power_q  <= 16'sd4915;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_RAISE_TARGET: raise_target_q <= cfg_data;
				REG_LOWER_TARGET: lower_target_q <= cfg_data;
				REG_CLIMB_TARGET: climb_target_q <= cfg_data;
				REG_PISTON_LIMIT: piston_limit_q <= cfg_data;
				REG_TILT_BAND:    tilt_band_q    <= cfg_data[14:0];
				REG_DEADBAND:     deadband_q     <= cfg_data[14:0];
				REG_ZERO_TIMEOUT: zero_timeout_q <= cfg_data[7:0];
				REG_CLIMB_POWER:  climb_power_q  <= cfg_data[PowW-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			homing_q       <= 1'b1;
			homing_ticks_q <= '0;
			seq_run_q      <= 1'b0;
			raised_q       <= 1'b0;
			climb_on_q     <= 1'b0;
			left_cmd_q     <= '0;
			right_cmd_q    <= '0;
			piston_q       <= PISTON_OFF;
			valid_s1       <= 1'b0;
			out_valid_q    <= 1'b0;
		end else begin
			if (item_ready) begin
				valid_s1 <= item_valid;
			end
			if (advance) begin
				out_valid_q    <= 1'b1;
				homing_q       <= homing_n;
				homing_ticks_q <= homing_ticks_n;
				seq_run_q      <= seq_run_n;
				raised_q       <= raised_n;
				climb_on_q     <= climb_on_n;
				left_cmd_q     <= left_n;
				right_cmd_q    <= right_n;
				piston_q       <= piston_n;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			item_s1 <= item;
		end
		if (advance) begin
			out_q.left_power       <= left_n;
			out_q.right_power      <= right_n;
			out_q.arm_piston       <= piston_n;
			out_q.reset_encoders   <= pulse_n;
			out_q.homing_active    <= homing_n;
			out_q.moving_arms      <= seq_run_n;
			out_q.arms_raised      <= raised_n;
			out_q.climbing_active  <= climb_on_n;
			out_q.request_consumed <= consumed_n;
		end
	end

	a_home_once: assert property (@(posedge clk) disable iff (!arst_n)
		!homing_q |=> !homing_q)
		else $error("homing restarted after it ended");

	a_ticks_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!homing_q |=> $stable(homing_ticks_q))
		else $error("homing tick count moved outside homing");

	a_pulse_ends_homing: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.reset_encoders) |-> !result.homing_active)
		else $error("encoder reset pulse while still homing");

	a_stall_has_item: assert property (@(posedge clk) disable iff (!arst_n)
		!item_ready |-> (valid_s1 && out_valid_q && !result_ready))
		else $error("input stalled without a blocked word");

	a_cmd_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.left_power <= FullScale && result.left_power >= -FullScale
			&& result.right_power <= FullScale && result.right_power >= -FullScale))
		else $error("motor command beyond full scale");

endmodule

FILE: dv/climber_arm_sequencer_tb.sv
module climber_arm_sequencer_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import cas_pkg::*;

	localparam int POS_MAX = 8388607;
	localparam int POS_MIN = -8388608;
	localparam int FULL_CMD = 16384;
	localparam int HOME_CMD = 1638;
	localparam int LEVEL_CMD = 3277;
	localparam int STICK_GAIN = 4915;
	localparam logic [7:0] TICK_CEIL = 8'd255;
	localparam int HOLD_CYCLES = 300;

	localparam logic [4:0] BTN_NONE    = 5'b00000;
	localparam logic [4:0] BTN_CONFIRM = 5'b00001;
	localparam logic [4:0] BTN_RAISE   = 5'b00010;
	localparam logic [4:0] BTN_CLIMB   = 5'b00100;
	localparam logic [4:0] BTN_REQ     = 5'b01000;
	localparam logic [4:0] BTN_REQ_UP  = 5'b10000;

	localparam logic [2:0] MODE_CLIMB  = 3'b001;
	localparam logic [2:0] MODE_MANUAL = 3'b010;
	localparam logic [2:0] MODE_AUTO   = 3'b100;

	localparam logic [1:0] LIM_BOTH  = 2'b11;

	logic clk;
	logic arst_n;
	logic item_valid;
	logic item_ready;
	in_word_t item;
	logic result_valid;
	logic result_ready;
	out_word_t result;
	logic cfg_we;
	logic [CfgIdxW-1:0] cfg_index;
	logic [CfgW-1:0] cfg_data;

	climber_arm_sequencer i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item(item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// shadow registers
	logic signed [23:0] raise_tgt = -24'sd20480;
	logic signed [23:0] lower_tgt = -24'sd1280;
	logic signed [23:0] climb_tgt = -24'sd7680;
	logic signed [23:0] piston_lim = -24'sd2560;
	logic [14:0] tilt_band_q = 15'd1024;
	logic [14:0] deadband_q = 15'd1638;
	logic [7:0] zero_to = 8'd75;
	logic signed [15:0] climb_pw = 16'sd4915;

	// sequencer state
	bit homing_q = 1'b1;
	logic [7:0] home_ticks = 8'd0;
	bit seq_run = 1'b0;
	bit raised_q = 1'b0;
	bit climb_q = 1'b0;
	int left_q = 0;
	int right_q = 0;
	logic [1:0] piston_q = PISTON_OFF;

	out_word_t predicted_words[$];
	int errors = 0;
	bit idle_on = 1'b1;
	int hold_requests = 0;
	int plant_l = 0;
	int plant_r = 0;
	out_word_t want;

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	function automatic int clamp_cmd(input int v);
		if (v > FULL_CMD) return FULL_CMD;
		if (v < -FULL_CMD) return -FULL_CMD;
		return v;
	endfunction

	function automatic int scale_stick_q(input int s);
		int mag;
		int q;
		mag = (s < 0) ? -s : s;
		q = (mag * STICK_GAIN + 8192) >>> 14;
		return (s < 0) ? -q : q;
	endfunction

	function automatic out_word_t predict_tick(input in_word_t w);
		out_word_t o;
		int lp, rp, tl, ls, rs, pw, band, db, rt, lt, ct, pl;
		bit lim_l, lim_r, climb_en, manual, auton, pulse, consumed;
		lp = int'(w.left_pos);
		rp = int'(w.right_pos);
		tl = int'(w.tilt);
		ls = int'(w.left_stick);
		rs = int'(w.right_stick);
		pw = int'(climb_pw);
		band = int'(tilt_band_q);
		db = int'(deadband_q);
		rt = int'(raise_tgt);
		lt = int'(lower_tgt);
		ct = int'(climb_tgt);
		pl = int'(piston_lim);
		lim_l = w.limits[0];
		lim_r = w.limits[1];
		climb_en = (w.modes & MODE_CLIMB) != 0;
		manual = (w.modes & MODE_MANUAL) != 0;
		auton = (w.modes & MODE_AUTO) != 0;
		pulse = 1'b0;
		consumed = 1'b0;
		if (homing_q) begin
			if (home_ticks != TICK_CEIL) home_ticks = home_ticks + 8'd1;
			if ((w.buttons & BTN_CONFIRM) != 0) begin
				pulse = 1'b1;
				left_q = 0;
				right_q = 0;
				homing_q = 1'b0;
			end else if (home_ticks > zero_to && auton) begin
				left_q = 0;
				right_q = 0;
			end else begin
				left_q = lim_l ? 0 : HOME_CMD;
				right_q = lim_r ? 0 : HOME_CMD;
				if (lim_l && lim_r) begin
					pulse = 1'b1;
					piston_q = PISTON_FWD;
					homing_q = 1'b0;
				end
			end
		end else if (manual) begin
			if (climb_en) begin
				climb_q = 1'b0;
				left_q = (ls > db || ls < -db) ? clamp_cmd(scale_stick_q(ls)) : 0;
				right_q = (rs > db || rs < -db) ? clamp_cmd(scale_stick_q(rs)) : 0;
				piston_q = (lp < pl || rp < pl) ? PISTON_REV : PISTON_FWD;
			end
		end else if (climb_en) begin
			if ((w.buttons & BTN_REQ) != 0) begin
				consumed = 1'b1;
				if (!climb_q && !raised_q && !seq_run)
					piston_q = ((w.buttons & BTN_REQ_UP) != 0) ? PISTON_FWD : PISTON_REV;
			end
			if ((w.buttons & BTN_RAISE) != 0) seq_run = 1'b1;
			if (seq_run && !raised_q) begin
				if (rp > rt || lp > rt) begin
					piston_q = PISTON_REV;
					left_q = (lp > rt) ? clamp_cmd(-pw) : 0;
					right_q = (rp > rt) ? clamp_cmd(-pw) : 0;
				end else begin
					left_q = 0;
					right_q = 0;
					raised_q = 1'b1;
					seq_run = 1'b0;
				end
			end else if (seq_run && raised_q) begin
				// arms still below the lower target are driven toward it with the climb power
				if (rp < lt || lp < lt) begin
					left_q = (lp < lt) ? clamp_cmd(pw) : 0;
					right_q = (rp < lt) ? clamp_cmd(pw) : 0;
				end else begin
					left_q = 0;
					right_q = 0;
					piston_q = PISTON_FWD;
					raised_q = 1'b0;
					seq_run = 1'b0;
				end
			end
			if ((w.buttons & BTN_CLIMB) != 0) climb_q = 1'b1;
			if (climb_q) begin
				if (lp < ct || rp < ct) begin
					// exactly on the band edge nothing is rewritten
					if (tl < band && tl > -band) begin
						left_q = clamp_cmd(pw);
						right_q = clamp_cmd(pw);
					end else if (tl > band) begin
						left_q = clamp_cmd(pw);
						right_q = 0;
					end else if (tl < -band) begin
						left_q = 0;
						right_q = clamp_cmd(pw);
					end
				end else begin
					if (tl > band) begin
						left_q = LEVEL_CMD;
					end else if (tl < -band) begin
						left_q = -LEVEL_CMD;
					end else begin
						left_q = 0;
						right_q = 0;
					end
				end
			end
		end
		o.left_power = left_q[15:0];
		o.right_power = right_q[15:0];
		o.arm_piston = piston_q;
		o.reset_encoders = pulse;
		o.homing_active = homing_q;
		o.moving_arms = seq_run;
		o.arms_raised = raised_q;
		o.climbing_active = climb_q;
		o.request_consumed = consumed;
		return o;
	endfunction

	function automatic int near_target();
		int t;
		int j;
		case ($urandom_range(0, 3))
			0: t = int'(raise_tgt);
			1: t = int'(lower_tgt);
			2: t = int'(climb_tgt);
			default: t = int'(piston_lim);
		endcase
		j = $urandom_range(0, 2);
		return t + j - 1;
	endfunction

	function automatic int rnd_target();
		int j;
		j = $urandom_range(0, 60000);
		return j - 30000;
	endfunction

	function automatic logic signed [23:0] pick_pos(input int plant);
		int j;
		int v;
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5, 6: begin
				j = $urandom_range(0, 64);
				v = plant + j - 32;
			end
			7, 8: v = near_target();
			default: v = $urandom;
		endcase
		return 24'(v);
	endfunction

	function automatic logic signed [15:0] pick_tilt();
		int v;
		int band;
		int j;
		band = int'(tilt_band_q);
		case ($urandom_range(0, 5))
			0: v = band;
			1: v = -band;
			2: v = band + 1;
			3: v = -band - 1;
			4: begin
				j = $urandom_range(0, 2 * band);
				v = j - band;
			end
			default: v = $urandom;
		endcase
		return 16'(v);
	endfunction

	function automatic logic signed [15:0] pick_stick();
		int v;
		case ($urandom_range(0, 4))
			0: v = int'(deadband_q);
			1: v = int'(deadband_q) + 1;
			2: v = FULL_CMD;
			3: v = 0;
			default: v = $urandom_range(0, FULL_CMD);
		endcase
		if (v > FULL_CMD) v = FULL_CMD;
		if ($urandom_range(0, 1)) v = -v;
		return 16'(v);
	endfunction

	function automatic in_word_t gen_word(input int manual_pct);
		in_word_t w;
		w.left_pos = pick_pos(plant_l);
		w.right_pos = pick_pos(plant_r);
		w.limits = 2'($urandom_range(0, 3));
		w.tilt = pick_tilt();
		w.left_stick = pick_stick();
		w.right_stick = pick_stick();
		w.buttons = BTN_NONE;
		if ($urandom_range(0, 1)) w.buttons = w.buttons | BTN_CONFIRM;
		if ($urandom_range(0, 19) == 0) w.buttons = w.buttons | BTN_RAISE;
		if ($urandom_range(0, 39) == 0) w.buttons = w.buttons | BTN_CLIMB;
		if ($urandom_range(0, 7) == 0) begin
			w.buttons = w.buttons | BTN_REQ;
			if ($urandom_range(0, 1)) w.buttons = w.buttons | BTN_REQ_UP;
		end
		if ($urandom_range(0, 15) == 0) w.buttons = 5'($urandom_range(0, 31));
		w.modes = MODE_CLIMB;
		if ($urandom_range(0, 99) < manual_pct) w.modes = w.modes | MODE_MANUAL;
		if ($urandom_range(0, 29) == 0) w.modes = w.modes & ~MODE_CLIMB;
		if ($urandom_range(0, 1)) w.modes = w.modes | MODE_AUTO;
		return w;
	endfunction

	function automatic in_word_t dir_word(input logic [2:0] m, input logic [4:0] b,
			input int lp, input int rp, input int tl, input int ls, input int rs);
		in_word_t w;
		w.left_pos = 24'(lp);
		w.right_pos = 24'(rp);
		w.limits = 2'($urandom_range(0, 3));
		w.tilt = 16'(tl);
		w.left_stick = 16'(ls);
		w.right_stick = 16'(rs);
		w.buttons = b;
		w.modes = m;
		return w;
	endfunction

	// arm position follows the held command, with an occasional jump
	function automatic int move_arm(input int pos, input int cmd);
		int p;
		if ($urandom_range(0, 63) == 0) return near_target();
		p = pos + (cmd >>> 4);
		if (p > POS_MAX) p = POS_MAX;
		if (p < POS_MIN) p = POS_MIN;
		return p;
	endfunction

	task automatic send_word(input in_word_t w);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		item_valid <= 1'b1;
		item <= w;
		@(posedge clk);
		while (!item_ready) @(posedge clk);
		predicted_words.push_back(predict_tick(w));
	endtask

	task automatic wait_idle();
		item_valid <= 1'b0;
		while (predicted_words.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_RAISE_TARGET: raise_tgt = val;
			REG_LOWER_TARGET: lower_tgt = val;
			REG_CLIMB_TARGET: climb_tgt = val;
			REG_PISTON_LIMIT: piston_lim = val;
			REG_TILT_BAND: tilt_band_q = val[14:0];
			REG_DEADBAND: deadband_q = val[14:0];
			REG_ZERO_TIMEOUT: zero_to = val[7:0];
			REG_CLIMB_POWER: climb_pw = val[15:0];
			default: ;
		endcase
	endtask

	task automatic apply_config(input int rt, input int lt, input int ct, input int pl,
			input int band, input int db, input int zt, input int pw);
		write_reg(REG_RAISE_TARGET, CfgW'(rt));
		write_reg(REG_LOWER_TARGET, CfgW'(lt));
		write_reg(REG_CLIMB_TARGET, CfgW'(ct));
		write_reg(REG_PISTON_LIMIT, CfgW'(pl));
		write_reg(REG_TILT_BAND, CfgW'(band));
		write_reg(REG_DEADBAND, CfgW'(db));
		write_reg(REG_ZERO_TIMEOUT, CfgW'(zt));
		write_reg(REG_CLIMB_POWER, CfgW'(pw));
	endtask

	task automatic run_mix(input int count, input int manual_pct);
		int i;
		for (i = 0; i < count; i++) begin
			send_word(gen_word(manual_pct));
			plant_l = move_arm(plant_l, left_q);
			plant_r = move_arm(plant_r, right_q);
		end
	endtask

	task automatic test_homing();
		in_word_t w;
		int i;
		// tick counter must saturate, so a timeout of 255 never fires
		write_reg(REG_ZERO_TIMEOUT, CfgW'(255));
		for (i = 0; i < 262; i++) begin
			w = gen_word(30);
			w.buttons = w.buttons & ~BTN_CONFIRM;
			w.limits = 2'($urandom_range(0, 2));
			if (i % 3 == 0) w.modes = w.modes | MODE_AUTO;
			send_word(w);
		end
		wait_idle();
		write_reg(REG_ZERO_TIMEOUT, CfgW'(0));
		for (i = 0; i < 12; i++) begin
			w = gen_word(30);
			w.buttons = w.buttons & ~BTN_CONFIRM;
			w.limits = 2'($urandom_range(0, 2));
			send_word(w);
		end
		// leave homing by the confirm button or by both switches
		w = gen_word(30);
		if ($urandom_range(0, 1)) begin
			w.buttons = w.buttons | BTN_CONFIRM;
		end else begin
			w.buttons = w.buttons & ~BTN_CONFIRM;
			w.limits = LIM_BOTH;
		end
		send_word(w);
		wait_idle();
	endtask

	task automatic test_directed();
		apply_config(-20480, -1280, -7680, -2560, 1024, 1638, 75, 4915);
		send_word(dir_word(MODE_CLIMB | MODE_MANUAL, BTN_NONE, POS_MAX, POS_MAX, 0,
			FULL_CMD, -FULL_CMD));
		send_word(dir_word(MODE_CLIMB | MODE_MANUAL, BTN_NONE, POS_MIN, 0, 0, 1638, -1639));
		send_word(dir_word(MODE_CLIMB | MODE_MANUAL | MODE_AUTO, BTN_NONE, 0, -2561, 0,
			-1638, 1639));
		// manual or semi-auto without climb enabled holds everything
		send_word(dir_word(MODE_MANUAL, BTN_NONE, POS_MIN, POS_MIN, 0, 9000, 9000));
		send_word(dir_word(MODE_AUTO, BTN_CONFIRM | BTN_RAISE | BTN_CLIMB | BTN_REQ | BTN_REQ_UP,
			0, 0, 0, 0, 0));
		send_word(dir_word(MODE_CLIMB, BTN_REQ, 0, 0, 0, 0, 0));
		send_word(dir_word(MODE_CLIMB | MODE_AUTO, BTN_REQ | BTN_REQ_UP, 0, 0, 0, 0, 0));
		// raise, then lower
		send_word(dir_word(MODE_CLIMB, BTN_RAISE, 0, 0, 0, 0, 0));
		send_word(dir_word(MODE_CLIMB, BTN_NONE, -20480, 0, 0, 0, 0));
		send_word(dir_word(MODE_CLIMB, BTN_NONE, -20480, -20481, 0, 0, 0));
		send_word(dir_word(MODE_CLIMB, BTN_REQ | BTN_REQ_UP, -20480, -20480, 0, 0, 0));
		send_word(dir_word(MODE_CLIMB, BTN_RAISE, -20480, -20480, 0, 0, 0));
		send_word(dir_word(MODE_CLIMB, BTN_NONE, -1280, -1281, 0, 0, 0));
		send_word(dir_word(MODE_CLIMB, BTN_NONE, -1280, -1279, 0, 0, 0));
		// climb below target, tilt on and past the band edges
		send_word(dir_word(MODE_CLIMB, BTN_CLIMB, POS_MIN, 0, 0, 0, 0));
		send_word(dir_word(MODE_CLIMB, BTN_NONE, POS_MIN, 0, 1024, 0, 0));
		send_word(dir_word(MODE_CLIMB, BTN_NONE, 0, POS_MIN, -1024, 0, 0));
		send_word(dir_word(MODE_CLIMB, BTN_NONE, POS_MIN, 0, 1025, 0, 0));
		send_word(dir_word(MODE_CLIMB, BTN_NONE, POS_MIN, 0, -1025, 0, 0));
		// leveling at height touches the left command only
		send_word(dir_word(MODE_CLIMB, BTN_NONE, POS_MAX, POS_MAX, 32767, 0, 0));
		send_word(dir_word(MODE_CLIMB, BTN_NONE, POS_MAX, POS_MAX, -32768, 0, 0));
		send_word(dir_word(MODE_CLIMB, BTN_REQ, POS_MAX, POS_MAX, 0, 0, 0));
		send_word(dir_word(MODE_CLIMB | MODE_MANUAL, BTN_NONE, 0, 0, 0, 0, 0));
		wait_idle();
	endtask

	task automatic test_manual();
		apply_config(-20480, -1280, -7680, rnd_target(), 1024, $urandom_range(0, FULL_CMD),
			75, 4915);
		run_mix(250, 90);
		wait_idle();
	endtask

	task automatic test_semi_auto();
		apply_config(-20480, -1280, -7680, -2560, 1024, 1638, 75, 4915);
		plant_l = 0;
		plant_r = 0;
		run_mix(480, 3);
		wait_idle();
	endtask

	task automatic test_backpressure();
		idle_on = 1'b0;
		hold_requests++;
		run_mix(40, 10);
		wait_idle();
		idle_on = 1'b1;
	endtask

	task automatic test_config_sweep();
		int k;
		int pw;
		apply_config(POS_MIN, POS_MAX, POS_MAX, POS_MIN, 0, 0, 0, FULL_CMD);
		run_mix(50, 20);
		wait_idle();
		apply_config(POS_MAX, POS_MIN, POS_MIN, POS_MAX, 32767, FULL_CMD, 255, -FULL_CMD);
		run_mix(50, 20);
		wait_idle();
		apply_config(rnd_target(), rnd_target(), rnd_target(), rnd_target(), 512, 800, 10, 0);
		run_mix(50, 20);
		wait_idle();
		for (k = 0; k < 3; k++) begin
			pw = $urandom_range(0, 2 * FULL_CMD);
			apply_config(rnd_target(), rnd_target(), rnd_target(), rnd_target(),
				$urandom_range(0, 4096), $urandom_range(0, FULL_CMD), $urandom_range(0, 255),
				pw - FULL_CMD);
			run_mix(50, 20);
			wait_idle();
		end
	endtask

	task automatic test_no_idle();
		apply_config(-20480, -1280, -7680, -2560, 1024, 1638, 75, 4915);
		idle_on = 1'b0;
		run_mix(100, 20);
		wait_idle();
	endtask

	task automatic check_field(input string name, input int exp_v, input int act_v);
		if (exp_v != act_v) begin
			errors++;
			$display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp_v, act_v);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n === 1'b1 && result_valid && result_ready) begin
			if (predicted_words.size() == 0) begin
				errors++;
				$display("%0t: unexpected result word, expected none actual %h", $time, result);
			end else begin
				want = predicted_words.pop_front();
				check_field("left_power", int'(want.left_power), int'(result.left_power));
				check_field("right_power", int'(want.right_power), int'(result.right_power));
				check_field("arm_piston", int'(want.arm_piston), int'(result.arm_piston));
				check_field("reset_encoders", int'(want.reset_encoders),
					int'(result.reset_encoders));
				check_field("homing_active", int'(want.homing_active),
					int'(result.homing_active));
				check_field("moving_arms", int'(want.moving_arms), int'(result.moving_arms));
				check_field("arms_raised", int'(want.arms_raised), int'(result.arms_raised));
				check_field("climbing_active", int'(want.climbing_active),
					int'(result.climbing_active));
				check_field("request_consumed", int'(want.request_consumed),
					int'(result.request_consumed));
			end
		end
	end

	// result side: random stalls plus the long hold-off on request
	initial begin : ready_driver
		int stall_left;
		int hold_left;
		int holds_seen;
		stall_left = 0;
		hold_left = 0;
		holds_seen = 0;
		result_ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (holds_seen != hold_requests) begin
				holds_seen = hold_requests;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				result_ready <= 1'b0;
			end else if (idle_on && $urandom_range(0, 9) == 0) begin
				stall_left = $urandom_range(0, 14);
				result_ready <= 1'b0;
			end else begin
				result_ready <= 1'b1;
			end
		end
	end

	initial begin
		#4000000;
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		arst_n <= 1'b0;
		item_valid <= 1'b0;
		item <= '0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_homing();
		test_directed();
		test_manual();
		test_semi_auto();
		test_backpressure();
		test_config_sweep();
		test_no_idle();
		repeat (8) @(posedge clk);
		if (errors == 0 && predicted_words.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

FILE: filelist.f
hw/rtl/cas_pkg.sv
hw/rtl/climber_arm_sequencer.sv
dv/climber_arm_sequencer_tb.sv
